FILE: design/hca_pkg.sv
// Package for the hybrid CA attractor analyzer.
// Holds the sizing constants; no dependencies.
package hca_pkg;
  localparam int MAX_CELLS_DEF = 10;
  localparam int RULE_W = 8;
  localparam int CNT_W = 11;
  localparam int CHAIN_W = 10;
endpackage

FILE: design/hca_if.sv
// Valid/ready stream interfaces for the analyzer.
// Depends on hca_pkg for field widths.
interface hca_in_if;
  logic                        valid;
  logic                        ready;
  logic [hca_pkg::RULE_W-1:0]  cell_rule;
  logic                        last_rule;
  modport source (output valid, cell_rule, last_rule, input ready);
  modport sink (input valid, cell_rule, last_rule, output ready);
endinterface

interface hca_out_if;
  logic                         valid;
  logic                         ready;
  logic [hca_pkg::CNT_W-1:0]    num_attractors;
  logic [hca_pkg::CNT_W-1:0]    num_point_attractors;
  logic [hca_pkg::CNT_W-1:0]    num_cyclic_attractors;
  logic [hca_pkg::CNT_W-1:0]    total_cycle_length;
  logic [hca_pkg::CNT_W-1:0]    max_cycle_length;
  logic [hca_pkg::CHAIN_W-1:0]  max_chain_length;
  logic                         irreversible;
  logic                         too_many_rules;
  modport source (output valid, num_attractors, num_point_attractors, num_cyclic_attractors,
                  total_cycle_length, max_cycle_length, max_chain_length, irreversible,
                  too_many_rules, input ready);
  modport sink (input valid, num_attractors, num_point_attractors, num_cyclic_attractors,
                total_cycle_length, max_cycle_length, max_chain_length, irreversible,
                too_many_rules, output ready);
endinterface

FILE: design/hybrid_ca_attractor_analyzer_top.sv
// Hybrid null-boundary CA attractor analyzer: rule load, graph walk, stats.
// Depends on hca_pkg and hca_if.sv.
// Operation: rules are accepted while idle. The last rule starts a job: a clear sweep of all
// 2^n states, a visited check per start state, walks that tag each state with its step and
// record the path, a close that marks the path entries visited, then an injectivity pass.
// Throughput: one job at a time; input stalls from the last rule until the result transfers.
// Reset: synchronous, active low; clears control state and counters, memories swept per job.
module hybrid_ca_attractor_analyzer_top #(
  parameter int MAX_CELLS = hca_pkg::MAX_CELLS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  hca_in_if.sink    in_ch,
  hca_out_if.source out_ch
);
  localparam int NS = 1 << MAX_CELLS;
  localparam int SW = MAX_CELLS;        // state width
  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int TW = SW + 1;           // start tag width (start+1)
  localparam int PW = SW + 1;           // step count width
  localparam int RULE_W_L = hca_pkg::RULE_W;
  localparam int CNT_L = hca_pkg::CNT_W;
  localparam int CH_L = hca_pkg::CHAIN_W;
  localparam int CNT_MAX = (1 << CNT_L) - 1;
  localparam int CH_MAX = (1 << CH_L) - 1;

  localparam logic [3:0] S_LOAD = 4'd0, S_CLR = 4'd1, S_SCAN = 4'd2, S_SCANW = 4'd3,
                         S_WRD = 4'd4, S_WCHK = 4'd5, S_EVAL = 4'd6, S_EVALW = 4'd7,
                         S_MARK = 4'd8, S_INJ = 4'd9, S_INJW = 4'd10, S_OUT = 4'd11,
                         S_INJR = 4'd12;

  logic [3:0] st_r;
  logic [RULE_W_L-1:0] rules_r [MAX_CELLS];
  logic [CW-1:0] cells_r;
  logic ovf_r;

  // memories: per-state visited, walk tag + step, successor seen; path list
  logic          vis_mem [NS];
  logic [TW+PW-1:0] tag_mem [NS];
  logic          seen_mem [NS];
  logic [SW-1:0] path_mem [NS];

  logic [SW-1:0] addr_r, start_r, cur_r;
  logic [PW-1:0] step_r, entry_r, k_r;
  logic          vis_q, seen_q;
  logic [TW+PW-1:0] tag_q;
  logic [SW-1:0] path_q;
  logic [CNT_L-1:0] att_r, pts_r, cyc_r, sum_r, maxc_r;
  logic [CH_L-1:0] chain_r;
  logic coll_r;
  logic [PW:0] total_w;

  function automatic logic [SW-1:0] nxt_state(input logic [SW-1:0] s,
                                               input logic [CW-1:0] n,
                                               input logic [RULE_W_L-1:0] r [MAX_CELLS]);
    logic [SW-1:0] o;
    logic l, c, rt;
    o = '0;
    for (int i = 0; i < SW; i++) begin
      l = (i > 0) ? s[(i > 0) ? i-1 : 0] : 1'b0;
      c = s[i];
      rt = (i + 1 < SW && (i + 1) < int'(n)) ? s[(i + 1 < SW) ? i+1 : i] : 1'b0;
      if (i < int'(n)) o[i] = r[i][{l, c, rt}];
    end
    return o;
  endfunction

  function automatic logic [CNT_L-1:0] sat_inc(input logic [CNT_L-1:0] v,
                                               input logic [CNT_L-1:0] a);
    logic [CNT_L:0] t;
    t = {1'b0, v} + {1'b0, a};
    return t[CNT_L] ? '1 : t[CNT_L-1:0];
  endfunction

  logic [SW-1:0] nxt_w;
  assign nxt_w = nxt_state(cur_r, cells_r, rules_r);
  assign total_w = (PW+1)'(1) << cells_r;
  wire [SW-1:0] last_st = SW'(total_w - 1'b1);
  wire [TW-1:0] tag_now = {1'b0, start_r} + 1'b1;
  wire [PW-1:0] len_w = step_r - entry_r;
  wire [CNT_L-1:0] len_sat = (int'(len_w) > CNT_MAX) ? '1 : CNT_L'(len_w);

  assign in_ch.ready = (st_r == S_LOAD);

  always_ff @(posedge clk) begin
    // synchronous (registered) memory reads
    vis_q  <= vis_mem[addr_r];
    tag_q  <= tag_mem[addr_r];
    seen_q <= seen_mem[addr_r];
    path_q <= path_mem[k_r[SW-1:0]];
    if (!rst_n) begin
      st_r <= S_LOAD; cells_r <= '0; ovf_r <= 1'b0; out_ch.valid <= 1'b0;
      att_r <= '0; pts_r <= '0; cyc_r <= '0; sum_r <= '0; maxc_r <= '0; chain_r <= '0;
      coll_r <= 1'b0;
    end else begin
      case (st_r)
        S_LOAD: if (in_ch.valid) begin
          if (int'(cells_r) < MAX_CELLS) begin
            rules_r[cells_r[$clog2(MAX_CELLS > 1 ? MAX_CELLS : 2)-1:0]] <= in_ch.cell_rule;
            cells_r <= cells_r + 1'b1;
          end else ovf_r <= 1'b1;
          if (in_ch.last_rule) begin
            st_r <= S_CLR; addr_r <= '0;
            att_r <= '0; pts_r <= '0; cyc_r <= '0; sum_r <= '0; maxc_r <= '0;
            chain_r <= '0; coll_r <= 1'b0;
          end
        end
        S_CLR: begin
          vis_mem[addr_r] <= 1'b0; tag_mem[addr_r] <= '0; seen_mem[addr_r] <= 1'b0;
          if (addr_r == last_st) begin
            st_r <= S_SCAN; addr_r <= '0; start_r <= '0;
          end else addr_r <= addr_r + 1'b1;
        end
        S_SCAN: st_r <= S_SCANW;  // wait for visited read of start
        S_SCANW: begin
          if (vis_q) begin
            if (start_r == last_st) begin
              st_r <= S_INJ; addr_r <= '0; cur_r <= '0;
            end else begin
              start_r <= start_r + 1'b1; addr_r <= start_r + 1'b1; st_r <= S_SCAN;
            end
          end else begin
            cur_r <= start_r; step_r <= '0; st_r <= S_WRD;
          end
        end
        S_WRD: st_r <= S_WCHK;    // tag read of cur in flight
        S_WCHK: begin
          if (tag_q[TW+PW-1:PW] == tag_now) begin
            entry_r <= tag_q[PW-1:0]; k_r <= tag_q[PW-1:0]; st_r <= S_EVAL;
          end else begin
            tag_mem[cur_r] <= {tag_now, step_r};
            path_mem[step_r[SW-1:0]] <= cur_r;
            step_r <= step_r + 1'b1;
            cur_r <= nxt_w; addr_r <= nxt_w; st_r <= S_WRD;
          end
        end
        S_EVAL: st_r <= S_EVALW;  // path read of entry
        S_EVALW: begin addr_r <= path_q; st_r <= S_MARK; k_r <= '0;
          if (int'(entry_r) > int'(chain_r))
            chain_r <= (int'(entry_r) > CH_MAX) ? '1 : CH_L'(entry_r);
        end
        S_MARK: begin
          // vis_q now holds visited of the cycle entry (first cycle only)
          if (k_r == '0 && !vis_q) begin
            att_r <= sat_inc(att_r, CNT_L'(1));
            sum_r <= sat_inc(sum_r, len_sat);
            if (len_sat > maxc_r) maxc_r <= len_sat;
            if (len_w == PW'(1)) pts_r <= sat_inc(pts_r, CNT_L'(1));
            else cyc_r <= sat_inc(cyc_r, CNT_L'(1));
          end
          k_r <= k_r + 1'b1;
          if (k_r == step_r) begin
            if (start_r == last_st) begin
              st_r <= S_INJ; cur_r <= '0;
            end else begin
              start_r <= start_r + 1'b1; addr_r <= start_r + 1'b1; st_r <= S_SCAN;
            end
          end
          if (k_r != '0) vis_mem[path_q] <= 1'b1;
        end
        S_INJ: begin addr_r <= nxt_w; st_r <= S_INJR; end
        S_INJR: st_r <= S_INJW;   // seen read of successor in flight
        S_INJW: begin
          if (seen_q) coll_r <= 1'b1;
          seen_mem[addr_r] <= 1'b1;
          if (cur_r == last_st) st_r <= S_OUT;
          else begin cur_r <= cur_r + 1'b1; st_r <= S_INJ; end
        end
        S_OUT: begin
          out_ch.valid <= 1'b1;
          if (out_ch.valid && out_ch.ready) begin
            out_ch.valid <= 1'b0; st_r <= S_LOAD; cells_r <= '0; ovf_r <= 1'b0;
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.num_attractors = att_r;
  assign out_ch.num_point_attractors = pts_r;
  assign out_ch.num_cyclic_attractors = cyc_r;
  assign out_ch.total_cycle_length = sum_r;
  assign out_ch.max_cycle_length = maxc_r;
  assign out_ch.max_chain_length = chain_r;
  assign out_ch.irreversible = coll_r;
  assign out_ch.too_many_rules = ovf_r;

  a_rdy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid) else $error("input ready while result pending");
  a_pts_le: assert property (@(posedge clk) disable iff (!rst_n)
    pts_r <= att_r) else $error("point count above attractor count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(att_r))
    else $error("result dropped before transfer");
endmodule

FILE: tb/hybrid_ca_attractor_analyzer_top_test.sv
// Testbench for the hybrid CA attractor analyzer: directed rule loads, then random jobs.
// Depends on hca_pkg, hca_if.sv and the analyzer top; checks results against a local predictor.
`timescale 1ns / 100ps

module hybrid_ca_attractor_analyzer_top_test;

  localparam int NCELLS      = hca_pkg::MAX_CELLS_DEF;
  localparam int NSTATE      = 1 << NCELLS;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int RAND_ITEMS  = 750;
  localparam int CW          = hca_pkg::CNT_W;
  localparam int CHW         = hca_pkg::CHAIN_W;
  localparam int CNT_MAX     = (1 << CW) - 1;
  localparam int CHAIN_MAX   = (1 << CHW) - 1;

  typedef struct packed {
    logic [CW-1:0]      attractors;
    logic [CW-1:0]      points;
    logic [CW-1:0]      cyclic;
    logic [CW-1:0]      cycle_sum;
    logic [CW-1:0]      max_cycle;
    logic [CHW-1:0]     max_chain;
    logic               irreversible;
    logic               too_many;
  } stats_t;

  typedef struct {
    logic [hca_pkg::RULE_W-1:0] rule;
    logic                       last;
    bit                         typed;
    stats_t                     want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hca_in_if  in_ch();
  hca_out_if out_ch();

  hybrid_ca_attractor_analyzer_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state: the rules of the current job and the graph walk scratch tables.
  logic [hca_pkg::RULE_W-1:0] job_rules [NCELLS];
  int                job_cells;
  bit                job_overflow;
  int                walk_owner [NSTATE];
  int                walk_index [NSTATE];
  int                path_buf [NSTATE];
  bit                visited [NSTATE];
  bit                hit [NSTATE];

  stats_t stats_due [$];
  row_t   rows [$];
  bit     failed = 1'b0;
  bit     quiet = 1'b0;
  int     cycles = 0;

  function automatic int sat(int v, int m);
    return (v > m) ? m : v;
  endfunction

  function automatic int successor(int s, int n);
    int r, l, c, rt;
    r = 0;
    for (int i = 0; i < n; i++) begin
      l  = (i > 0) ? ((s >> (i - 1)) & 1) : 0;
      c  = (s >> i) & 1;
      rt = (i + 1 < n) ? ((s >> (i + 1)) & 1) : 0;
      r |= int'(job_rules[i][l * 4 + c * 2 + rt]) << i;
    end
    return r;
  endfunction

  function automatic stats_t graph_stats(int n);
    stats_t st;
    int cur, steps, entry, len, att, pts, sum, mcyc, mchain, t;
    bit coll;
    att = 0; pts = 0; sum = 0; mcyc = 0; mchain = 0; coll = 1'b0;
    for (int s = 0; s < NSTATE; s++) begin
      walk_owner[s] = 0; walk_index[s] = 0; visited[s] = 1'b0; hit[s] = 1'b0;
    end
    for (int start = 0; start < (1 << n); start++) begin
      if (!visited[start]) begin
        cur = start;
        steps = 0;
        while (walk_owner[cur] != start + 1) begin
          walk_owner[cur] = start + 1;
          walk_index[cur] = steps;
          path_buf[steps] = cur;
          steps++;
          cur = successor(cur, n);
        end
        entry = walk_index[cur];
        len = steps - entry;
        if (entry > mchain) mchain = entry;
        if (!visited[path_buf[entry]]) begin
          att++;
          sum += len;
          if (len > mcyc) mcyc = len;
          if (len == 1) pts++;
        end
        for (int k = 0; k < steps; k++) visited[path_buf[k]] = 1'b1;
      end
    end
    for (int s = 0; s < (1 << n); s++) begin
      t = successor(s, n);
      if (hit[t]) coll = 1'b1;
      hit[t] = 1'b1;
    end
    st.attractors   = CW'(sat(att, CNT_MAX));
    st.points       = CW'(sat(pts, CNT_MAX));
    st.cyclic       = CW'(sat(att - pts, CNT_MAX));
    st.cycle_sum    = CW'(sat(sum, CNT_MAX));
    st.max_cycle    = CW'(sat(mcyc, CNT_MAX));
    st.max_chain    = CHW'(sat(mchain, CHAIN_MAX));
    st.irreversible = coll;
    st.too_many     = job_overflow;
    return st;
  endfunction

  // Track one accepted rule; on the last one queue the expected statistics.
  task automatic absorb(logic [hca_pkg::RULE_W-1:0] rule, logic last, bit typed,
                        stats_t want);
    stats_t due;
    if (job_cells < NCELLS) begin
      job_rules[job_cells] = rule;
      job_cells++;
    end else begin
      job_overflow = 1'b1;
    end
    if (last) begin
      due = typed ? want : graph_stats(job_cells);
      stats_due = {stats_due, due};
      job_cells = 0;
      job_overflow = 1'b0;
    end
  endtask

  task automatic send_rule(logic [hca_pkg::RULE_W-1:0] rule, logic last, bit typed,
                           stats_t want);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cell_rule <= rule;
    in_ch.last_rule <= last;
    do @(posedge clk); while (!in_ch.ready);
    absorb(rule, last, typed, want);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [hca_pkg::RULE_W-1:0] rule, logic last, bit typed,
                                  stats_t want);
    row_t r;
    r.rule = rule; r.last = last; r.typed = typed; r.want = want;
    rows = {rows, r};
  endfunction

  // Result side: random stall bursts, none once the run goes quiet.
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (quiet) begin
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    stats_t got, want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.num_attractors, out_ch.num_point_attractors,
              out_ch.num_cyclic_attractors, out_ch.total_cycle_length,
              out_ch.max_cycle_length, out_ch.max_chain_length,
              out_ch.irreversible, out_ch.too_many_rules};
      if (stats_due.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        failed = 1'b1;
      end else begin
        want = stats_due.pop_front();
        if (got.attractors !== want.attractors)
          $display("%0t: num_attractors exp %0d got %0d", $time, want.attractors, got.attractors);
        if (got.points !== want.points)
          $display("%0t: num_point_attractors exp %0d got %0d", $time, want.points, got.points);
        if (got.cyclic !== want.cyclic)
          $display("%0t: num_cyclic_attractors exp %0d got %0d", $time, want.cyclic, got.cyclic);
        if (got.cycle_sum !== want.cycle_sum)
          $display("%0t: total_cycle_length exp %0d got %0d", $time, want.cycle_sum,
                   got.cycle_sum);
        if (got.max_cycle !== want.max_cycle)
          $display("%0t: max_cycle_length exp %0d got %0d", $time, want.max_cycle,
                   got.max_cycle);
        if (got.max_chain !== want.max_chain)
          $display("%0t: max_chain_length exp %0d got %0d", $time, want.max_chain,
                   got.max_chain);
        if (got.irreversible !== want.irreversible)
          $display("%0t: irreversible exp %0b got %0b", $time, want.irreversible,
                   got.irreversible);
        if (got.too_many !== want.too_many)
          $display("%0t: too_many_rules exp %0b got %0b", $time, want.too_many, got.too_many);
        if (got !== want) failed = 1'b1;
      end
    end
  end

  initial begin
    stats_t none;
    int sent, len;
    none = '0;
    job_cells = 0;
    job_overflow = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cell_rule = '0;
    in_ch.last_rule = 1'b0;

    // Single cells: constant maps, identity and inversion.
    add_row(8'h00, 1'b1, 1'b1, '{11'd1, 11'd1, 11'd0, 11'd1, 11'd1, 10'd1, 1'b1, 1'b0});
    add_row(8'hFF, 1'b1, 1'b1, '{11'd1, 11'd1, 11'd0, 11'd1, 11'd1, 10'd1, 1'b1, 1'b0});
    add_row(8'h04, 1'b1, 1'b1, '{11'd2, 11'd2, 11'd0, 11'd2, 11'd1, 10'd0, 1'b0, 1'b0});
    add_row(8'h01, 1'b1, 1'b1, '{11'd1, 11'd0, 11'd1, 11'd2, 11'd2, 10'd0, 1'b0, 1'b0});
    // Full rule store of mixed rules.
    for (int i = 0; i < NCELLS; i++)
      add_row((i % 2) ? 8'h96 : 8'h5A, i == NCELLS - 1, 1'b0, none);
    // One rule too many: the excess is dropped and flagged.
    for (int i = 0; i <= NCELLS; i++)
      add_row(8'h1E + 8'(i), i == NCELLS, 1'b0, none);

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_rule(rows[i].rule, rows[i].last, rows[i].typed, rows[i].want);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      len = $urandom_range(0, 99);
      if (len < 80)      len = $urandom_range(1, 5);
      else if (len < 92) len = $urandom_range(6, 9);
      else if (len < 97) len = NCELLS;
      else               len = $urandom_range(NCELLS + 1, NCELLS + 3);
      if (sent > RAND_ITEMS * 9 / 10) quiet = 1'b1;
      for (int k = 0; k < len; k++)
        send_rule(8'($urandom_range(0, 255)), k == len - 1, 1'b0, none);
      sent += len;
    end
    in_ch.valid <= 1'b0;

    while (stats_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
